[rtl/rtul_pkg.sv]
`timescale 1ns / 1ps

package rtul_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 16;
   localparam logic [15:0] HYST_RESET        = 16'd5;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_UNCHANGED = 3'd2,
      ST_FULL      = 3'd3,
      ST_HIT       = 3'd4,
      ST_MISS      = 3'd5
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [63:0] dest_addr;
      logic [63:0] next_hop_in;
      logic [7:0]  hop_total;
      logic [15:0] link_metric;
      logic [15:0] seq_number;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] next_hop_out;
   } rsp_type;

   // request in flight along the cell row
   typedef struct packed {
      logic        valid;
      logic        done;
      op_type      operation;
      logic [63:0] dest_addr;
      logic [63:0] next_hop_in;
      logic [15:0] link_metric;
      status_type  status;
      logic [63:0] next_hop_out;
   } token_type;

endpackage

[rtl/rtul_cell.sv]
`timescale 1ns / 1ps

module rtul_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         hyst,
   input  rtul_pkg::token_type tok_i,
   output rtul_pkg::token_type tok_o
);

   logic                entry_valid_ff;
   logic                entry_valid_in;
   logic [63:0]         entry_dest_ff;
   logic [63:0]         entry_next_hop_ff;
   logic [15:0]         entry_metric_ff;
   logic [15:0]         entry_metric_in;
   logic                entry_load;
   rtul_pkg::token_type tok_ff;
   rtul_pkg::token_type tok_in;
   logic                hit;
   logic [16:0]         diff;
   logic [16:0]         mag;

   assign hit  = entry_valid_ff && (entry_dest_ff == tok_i.dest_addr);
   // exact difference of sign-extended metrics
   assign diff = {entry_metric_ff[15], entry_metric_ff}
               - {tok_i.link_metric[15], tok_i.link_metric};
   assign mag  = diff[16] ? (17'd0 - diff) : diff;

   always_comb begin
      tok_in          = tok_i;
      entry_valid_in  = entry_valid_ff;
      entry_metric_in = entry_metric_ff;
      entry_load      = 1'b0;
      if (tok_i.valid && !tok_i.done) begin
         if (hit) begin
            tok_in.done = 1'b1;
            if (tok_i.operation == rtul_pkg::OP_LOOKUP) begin
               tok_in.status       = rtul_pkg::ST_HIT;
               tok_in.next_hop_out = entry_next_hop_ff;
            end else if (mag > {1'b0, hyst}) begin
               tok_in.status   = rtul_pkg::ST_UPDATED;
               entry_metric_in = tok_i.link_metric;
            end else begin
               tok_in.status = rtul_pkg::ST_UNCHANGED;
            end
         end else if (!entry_valid_ff && tok_i.operation == rtul_pkg::OP_UPDATE) begin
            // first free slot, entries fill in order
            tok_in.done     = 1'b1;
            tok_in.status   = rtul_pkg::ST_INSERTED;
            entry_valid_in  = 1'b1;
            entry_metric_in = tok_i.link_metric;
            entry_load      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         tok_ff.valid   <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         tok_ff         <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_metric_ff <= entry_metric_in;
      if (entry_load) begin
         entry_dest_ff     <= tok_i.dest_addr;
         entry_next_hop_ff <= tok_i.next_hop_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

[rtl/route_table_update_lookup_top.sv]
// channel   ports                          handshake
// request   start, busy, req_data          taken when start high and busy low
// response  rsp_strobe, rsp_data           one cycle, taken at the edge ending it
// config    csr_wr_en, csr_wr_data         written when csr_wr_en high
//
// a request walks the row of TABLE_ENTRIES cells, one cell per cycle
// the response strobes once the request has left the last cell, and busy
// drops in that same cycle, so the block holds only one request at a time
// synchronous active-high reset empties the table and sets the hysteresis to 5
// the receiver cannot stall the response
`timescale 1ns / 1ps

module route_table_update_lookup_top #(
   parameter int unsigned TABLE_ENTRIES = rtul_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rtul_pkg::req_type req_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   output logic              rsp_strobe,
   output rtul_pkg::rsp_type rsp_data
);

   logic                 accept;
   logic                 busy_ff;
   logic                 busy_in;
   logic [15:0]          hyst_ff;
   logic                 rsp_strobe_ff;
   rtul_pkg::rsp_type    rsp_ff;
   rtul_pkg::rsp_type    rsp_in;
   rtul_pkg::token_type  tok_chain [TABLE_ENTRIES+1];
   rtul_pkg::token_type  tail;
   logic [TABLE_ENTRIES-1:0] tok_vld;

   assign accept = start && !busy_ff;

   // metric hysteresis register
   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff <= rtul_pkg::HYST_RESET;
      end else if (csr_wr_en) begin
         hyst_ff <= csr_wr_data;
      end
   end

   // head of the row: the new request enters cell 0
   always_comb begin
      tok_chain[0].valid        = accept;
      tok_chain[0].done         = 1'b0;
      tok_chain[0].operation    = req_data.operation;
      tok_chain[0].dest_addr    = req_data.dest_addr;
      tok_chain[0].next_hop_in  = req_data.next_hop_in;
      tok_chain[0].link_metric  = req_data.link_metric;
      tok_chain[0].status       = rtul_pkg::ST_MISS;
      tok_chain[0].next_hop_out = 64'd0;
   end

   // one cell per route, each compares and updates its own entry
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      rtul_cell u_cell (
         .clock (clock),
         .reset (reset),
         .hyst  (hyst_ff),
         .tok_i (tok_chain[i]),
         .tok_o (tok_chain[i+1])
      );
      assign tok_vld[i] = tok_chain[i+1].valid;
   end

   assign tail = tok_chain[TABLE_ENTRIES];

   // a request that left the row unresolved found neither its key nor a free slot
   always_comb begin
      if (tail.done) begin
         rsp_in.status       = tail.status;
         rsp_in.next_hop_out = tail.next_hop_out;
      end else begin
         rsp_in.status       = (tail.operation == rtul_pkg::OP_LOOKUP) ?
                               rtul_pkg::ST_MISS : rtul_pkg::ST_FULL;
         rsp_in.next_hop_out = 64'd0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= tail.valid;
      end
   end

   // response payload, held between strobes
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // at most one request travels the row
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vld))
      else $error("more than one request in the cell row");

   // busy ends exactly when the response strobes
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_strobe_ff)
      else $error("busy dropped without a response");

   // a response never strobes while a request is still held
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy_ff)
      else $error("response strobe while busy");

   // after a request is taken, busy is high and no response strobes
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && !rsp_strobe_ff))
      else $error("busy not raised after a request was taken");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int TABLE_DEPTH = rtul_pkg::TABLE_ENTRIES_DEF;
   localparam int POOL_KEYS   = 24;    // more keys than slots, so the table overflows
   localparam int PHASE_REQS  = 610;
   localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
   localparam int PRINT_CAP   = 50;

   // what the request queue can hold: requests, register writes and idle settings
   typedef enum logic [1:0] {
      ENT_REQ,
      ENT_CSR,
      ENT_IDLE
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type    kind;
      rtul_pkg::req_type rq;
      logic [15:0]       value;
   } stim_entry_type;

   // dut connections, inputs known from time zero
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   rtul_pkg::req_type req_data    = '0;
   logic              csr_wr_en   = 1'b0;
   logic [15:0]       csr_wr_data = '0;
   logic              rsp_strobe;
   rtul_pkg::rsp_type rsp_data;

   // pending requests and register writes, filled up front
   stim_entry_type    stim_q[$];
   // responses still owed by the table, oldest first
   rtul_pkg::rsp_type route_expect_q[$];

   // shadow routing table
   logic               route_valid    [TABLE_DEPTH];
   logic [63:0]        route_dest     [TABLE_DEPTH];
   logic [63:0]        route_next_hop [TABLE_DEPTH];
   logic [7:0]         route_hops     [TABLE_DEPTH];
   logic signed [15:0] route_metric   [TABLE_DEPTH];
   logic [15:0]        route_seq      [TABLE_DEPTH];
   int                 route_count;
   logic [15:0]        hyst_now;

   // bookkeeping shared by driver, monitor and end of run
   int issued_total     = 0;
   int taken_total      = 0;
   int checked_total    = 0;
   int csr_write_total  = 0;
   int mismatch_count   = 0;
   int quiet_cycles     = 0;
   int idle_pct         = 0;
   int status_tally [6] = '{default: 0};

   route_table_update_lookup_top u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // reset held from time zero, then released on a falling edge
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // expected response for one request, shadow table advanced as the block does
   function automatic rtul_pkg::rsp_type predict_route_result(input rtul_pkg::req_type rq);
      rtul_pkg::rsp_type res;
      int                slot;
      int                diff;
      int                mag;
      res  = '0;
      slot = -1;
      // first valid match wins, only filled slots are looked at
      for (int i = 0; i < route_count; i++) begin
         if (slot < 0 && route_valid[i] && route_dest[i] == rq.dest_addr)
            slot = i;
      end
      if (rq.operation == rtul_pkg::OP_LOOKUP) begin
         if (slot >= 0) begin
            res.status       = rtul_pkg::ST_HIT;
            res.next_hop_out = route_next_hop[slot];
         end else begin
            res.status = rtul_pkg::ST_MISS;
         end
      end else if (slot < 0) begin
         if (route_count < TABLE_DEPTH) begin
            route_valid[route_count]    = 1'b1;
            route_dest[route_count]     = rq.dest_addr;
            route_next_hop[route_count] = rq.next_hop_in;
            route_hops[route_count]     = rq.hop_total;
            route_metric[route_count]   = rq.link_metric;
            route_seq[route_count]      = rq.seq_number;
            route_count++;
            res.status = rtul_pkg::ST_INSERTED;
         end else begin
            res.status = rtul_pkg::ST_FULL;
         end
      end else begin
         // exact difference of sign-extended metrics, no wrap
         diff = int'(route_metric[slot]) - int'($signed(rq.link_metric));
         mag  = (diff < 0) ? -diff : diff;
         if (mag > int'(hyst_now)) begin
            route_metric[slot] = rq.link_metric;
            res.status = rtul_pkg::ST_UPDATED;
         end else begin
            res.status = rtul_pkg::ST_UNCHANGED;
         end
      end
      return res;
   endfunction

   // one line per mismatch, printing capped to keep the log short
   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_request(input rtul_pkg::op_type op, input logic [63:0] dest,
                                input logic [63:0] nh, input logic [7:0] hops,
                                input logic [15:0] metric, input logic [15:0] seq);
      stim_entry_type e;
      e                = '0;
      e.kind           = ENT_REQ;
      e.rq.operation   = op;
      e.rq.dest_addr   = dest;
      e.rq.next_hop_in = nh;
      e.rq.hop_total   = hops;
      e.rq.link_metric = metric;
      e.rq.seq_number  = seq;
      stim_q.push_back(e);
   endtask

   task automatic queue_marker(input entry_kind_type kind, input logic [15:0] value);
      stim_entry_type e;
      e       = '0;
      e.kind  = kind;
      e.value = value;
      stim_q.push_back(e);
   endtask

   // driver: changes inputs on the falling edge
   // a request stays on the bus until the monitor has seen it taken
   always @(negedge clock) begin : request_driver
      stim_entry_type head;
      logic           hold;
      logic           wr;
      hold = start && (taken_total != issued_total);
      wr   = 1'b0;
      if (!reset && !hold && stim_q.size() > 0) begin
         head = stim_q[0];
         case (head.kind)
            ENT_IDLE: begin
               idle_pct = int'(head.value);
               stim_q.delete(0);
            end
            ENT_CSR: begin
               // register writes only once the table has answered everything
               if (!start && route_expect_q.size() == 0 && busy === 1'b0) begin
                  wr = 1'b1;
                  csr_wr_data <= head.value;
                  stim_q.delete(0);
               end
            end
            default: begin
               // random gaps between requests
               if ($urandom_range(99) >= idle_pct) begin
                  hold = 1'b1;
                  req_data <= head.rq;
                  issued_total++;
                  stim_q.delete(0);
               end
            end
         endcase
      end
      start     <= hold && !reset;
      csr_wr_en <= wr;
   end

   // monitor: samples on the rising edge, checks responses before predicting new ones
   always @(posedge clock) begin : route_monitor
      rtul_pkg::rsp_type want;
      logic              moved;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++)
            route_valid[i] = 1'b0;
         route_count  = 0;
         hyst_now     = rtul_pkg::HYST_RESET;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_wr_en) begin
            hyst_now = csr_wr_data;
            csr_write_total++;
            moved = 1'b1;
         end
         if (rsp_strobe !== 1'b0) begin
            moved = 1'b1;
            if (route_expect_q.size() == 0) begin
               flag_mismatch("response with nothing pending", rsp_data.next_hop_out, '0);
            end else begin
               want = route_expect_q.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.next_hop_out !== want.next_hop_out)
                  flag_mismatch("next_hop_out", rsp_data.next_hop_out, want.next_hop_out);
               status_tally[want.status]++;
               checked_total++;
            end
         end
         if (start && busy === 1'b0) begin
            route_expect_q.push_back(predict_route_result(req_data));
            taken_total++;
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         // nothing moving for this long means a hung block
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d responses owed",
                     STALL_LIMIT, route_expect_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // stimulus plan and end of run
   initial begin : route_stimulus
      logic [63:0] key_pool   [POOL_KEYS];
      int          gen_metric [POOL_KEYS];
      int          phase_idle [3];
      int          phase_hyst [3];
      int          gen_hyst;
      int          span;
      int          pick;
      int          k;
      int          m;
      logic [63:0] fresh;

      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_KEYS; i++)
         key_pool[i] = {$urandom, $urandom};

      // directed part, sender idles lightly
      queue_marker(ENT_IDLE, 16);
      // lookup on an empty table
      queue_request(rtul_pkg::OP_LOOKUP, '0, {$urandom, $urandom}, 8'h5a, 16'h1234,
                    16'h4321);
      // inserts at the field extremes
      queue_request(rtul_pkg::OP_UPDATE, '0, '1, 8'hff, 16'h8000, 16'hffff);
      queue_request(rtul_pkg::OP_UPDATE, '1, '0, 8'h00, 16'h7fff, 16'h0000);
      // hits, one returning an all-ones and one an all-zero next hop
      queue_request(rtul_pkg::OP_LOOKUP, '0, {$urandom, $urandom}, 8'($urandom),
                    16'($urandom), 16'($urandom));
      queue_request(rtul_pkg::OP_LOOKUP, '1, {$urandom, $urandom}, 8'($urandom),
                    16'($urandom), 16'($urandom));
      // change equal to the hysteresis keeps the metric, one more replaces it
      queue_request(rtul_pkg::OP_UPDATE, '0, {$urandom, $urandom}, 8'($urandom),
                    16'h8005, 16'($urandom));
      queue_request(rtul_pkg::OP_UPDATE, '0, {$urandom, $urandom}, 8'($urandom),
                    16'h8006, 16'($urandom));
      queue_request(rtul_pkg::OP_UPDATE, '0, {$urandom, $urandom}, 8'($urandom),
                    16'h8006, 16'($urandom));
      // widest possible swing against the largest hysteresis
      queue_marker(ENT_CSR, 16'hffff);
      queue_request(rtul_pkg::OP_UPDATE, '1, {$urandom, $urandom}, 8'($urandom),
                    16'h8000, 16'($urandom));
      queue_marker(ENT_CSR, 16'hfffe);
      queue_request(rtul_pkg::OP_UPDATE, '1, {$urandom, $urandom}, 8'($urandom),
                    16'h8000, 16'($urandom));
      // zero hysteresis, any change counts
      queue_marker(ENT_CSR, 16'h0000);
      queue_request(rtul_pkg::OP_UPDATE, '1, {$urandom, $urandom}, 8'($urandom),
                    16'h8001, 16'($urandom));
      queue_request(rtul_pkg::OP_UPDATE, '1, {$urandom, $urandom}, 8'($urandom),
                    16'h8001, 16'($urandom));
      gen_metric[0] = -32762;
      gen_metric[1] = -32767;
      // fill the remaining slots
      for (int i = 2; i < POOL_KEYS; i++) begin
         gen_metric[i] = int'($signed(16'($urandom)));
         if (i < TABLE_DEPTH)
            queue_request(rtul_pkg::OP_UPDATE, key_pool[i], {$urandom, $urandom},
                          8'($urandom), 16'(gen_metric[i]), 16'($urandom));
      end
      // table full: new key refused, then missed, last slot still found
      queue_request(rtul_pkg::OP_UPDATE, key_pool[TABLE_DEPTH], {$urandom, $urandom},
                    8'($urandom), 16'($urandom), 16'($urandom));
      queue_request(rtul_pkg::OP_LOOKUP, key_pool[TABLE_DEPTH], '1, 8'($urandom),
                    16'($urandom), 16'($urandom));
      queue_request(rtul_pkg::OP_LOOKUP, key_pool[TABLE_DEPTH - 1], '0, 8'($urandom),
                    16'($urandom), 16'($urandom));

      // random phases: light sender idling, heavy idling, then back to back
      phase_idle = '{16, 71, 0};
      phase_hyst = '{int'(rtul_pkg::HYST_RESET), $urandom_range(1, 300),
                     $urandom_range(0, 20)};
      for (int ph = 0; ph < 3; ph++) begin
         gen_hyst = phase_hyst[ph];
         span     = (gen_hyst > 200) ? 200 : gen_hyst;
         queue_marker(ENT_CSR, 16'(gen_hyst));
         queue_marker(ENT_IDLE, 16'(phase_idle[ph]));
         for (int n = 0; n < PHASE_REQS; n++) begin
            pick  = $urandom_range(99);
            k     = $urandom_range(POOL_KEYS - 1);
            fresh = {$urandom, $urandom};
            // metrics mostly straddle the hysteresis band around the last stored value
            if ($urandom_range(9) == 0) begin
               m = int'($signed(16'($urandom)));
            end else begin
               m = gen_metric[k] + int'($urandom_range(0, 2 * span + 4)) - (span + 2);
               if (m > 32767)
                  m = 32767;
               if (m < -32768)
                  m = -32768;
            end
            if (pick < 45) begin
               if ((m - gen_metric[k] > gen_hyst) || (gen_metric[k] - m > gen_hyst))
                  gen_metric[k] = m;
               queue_request(rtul_pkg::OP_UPDATE, key_pool[k], {$urandom, $urandom},
                             8'($urandom), 16'(m), 16'($urandom));
            end else if (pick < 80) begin
               queue_request(rtul_pkg::OP_LOOKUP, key_pool[k], {$urandom, $urandom},
                             8'($urandom), 16'(m), 16'($urandom));
            end else if (pick < 90) begin
               queue_request(rtul_pkg::OP_UPDATE, fresh, {$urandom, $urandom},
                             8'($urandom), 16'($urandom), 16'($urandom));
            end else begin
               queue_request(rtul_pkg::OP_LOOKUP, fresh, {$urandom, $urandom},
                             8'($urandom), 16'($urandom), 16'($urandom));
            end
         end
      end

      // drain: everything sent, taken and answered
      while (stim_q.size() > 0 || start || csr_wr_en || route_expect_q.size() > 0)
         @(posedge clock);
      // room for a stray late response to show up
      repeat (TABLE_DEPTH + 4) @(posedge clock);

      $display("run covered %0d requests across %0d hysteresis writes",
               checked_total, csr_write_total);
      $display("inserted %0d, updated %0d, unchanged %0d, full %0d, hit %0d, miss %0d",
               status_tally[rtul_pkg::ST_INSERTED], status_tally[rtul_pkg::ST_UPDATED],
               status_tally[rtul_pkg::ST_UNCHANGED], status_tally[rtul_pkg::ST_FULL],
               status_tally[rtul_pkg::ST_HIT], status_tally[rtul_pkg::ST_MISS]);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/rtul_pkg.sv
rtl/rtul_cell.sv
rtl/route_table_update_lookup_top.sv
sim/tb_top.sv
